// ===== design/euler_angles_to_matrix_core_macros.svh =====
// Assertion macros shared by the rotation matrix core.
// No dependencies; included by the top core file, which checks its own logic.
`ifndef EULER_ANGLES_TO_MATRIX_CORE_MACROS_SVH
`define EULER_ANGLES_TO_MATRIX_CORE_MACROS_SVH

// Same-cycle implication under reset.
`define EATM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication under reset.
`define EATM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ===== design/eatm_pkg.sv =====
// Package for the rotation matrix core: widths, CORDIC constants, types.
// Holds angle wrapping, saturation and output rounding helpers.
`default_nettype none
package eatm_pkg;

   localparam int COEF_BITS     = 16;
   localparam int CORDIC_STAGES = 16;

   localparam int ANG_W   = 16;
   localparam int POS_W   = 19;
   localparam int OUT_W   = 16;
   localparam int OUT_FRAC = 14;
   localparam int OUT_ONE = 16384;
   localparam int LW      = COEF_BITS + 3;     // CORDIC x/y width
   localparam int CW      = COEF_BITS + 2;     // saturated sin/cos width
   localparam int ZW      = 29;                // residual angle, deg * 2^20
   localparam int PW      = 2 * CW;            // product width
   localparam int SW      = PW + 1;            // sum width
   localparam int SH      = 2 * COEF_BITS - OUT_FRAC;
   localparam int IDX_W   = 5;
   localparam int IN_W    = 112;
   localparam int RSP_W   = 208;

   localparam logic signed [17:0] TURN_UNITS    = 18'sd23040;
   localparam logic signed [17:0] HALF_UNITS    = 18'sd11520;
   localparam logic signed [17:0] QUARTER_UNITS = 18'sd5760;
   localparam longint GAIN_Q30 = 64'd652032874;
   localparam logic signed [LW-1:0] X_START = LW'(GAIN_Q30 >> (30 - COEF_BITS));
   localparam logic signed [LW-1:0] ONE_L = LW'(longint'(1) << COEF_BITS);

   // atan(2^-i) in degrees * 2^20
   localparam logic [ZW-1:0] ATAN_TAB [0:23] = '{
      29'd47185920, 29'd27855475, 29'd14718068, 29'd7471121, 29'd3750058,
      29'd1876857, 29'd938658, 29'd469357, 29'd234682, 29'd117342, 29'd58671,
      29'd29335, 29'd14668, 29'd7334, 29'd3667, 29'd1833, 29'd917, 29'd458,
      29'd229, 29'd115, 29'd57, 29'd29, 29'd14, 29'd7
   };

   typedef struct packed {
      logic [LW-1:0] x;
      logic [LW-1:0] y;
      logic [ZW-1:0] z;
   } lane_type;

   typedef struct packed {
      logic              valid;
      lane_type [2:0]    lane;
      logic [2:0]        neg;
      logic [3*POS_W-1:0] pos;
   } pipe_type;

   typedef struct packed {
      logic     neg;
      lane_type lane;
   } start_type;

   // Wrap to [-180,180), fold beyond +-90 degrees, seed the CORDIC.
   function automatic start_type wrap_angle(input logic [ANG_W-1:0] raw);
      logic signed [17:0] a;
      start_type r;
      a = 18'($signed(raw));
      r.neg = 1'b0;
      if (a >= HALF_UNITS) a = a - TURN_UNITS;
      else if (a < -HALF_UNITS) a = a + TURN_UNITS;
      if (a > QUARTER_UNITS) begin
         a = HALF_UNITS - a;
         r.neg = 1'b1;
      end else if (a < -QUARTER_UNITS) begin
         a = -HALF_UNITS - a;
         r.neg = 1'b1;
      end
      r.lane.x = X_START;
      r.lane.y = '0;
      r.lane.z = ZW'(a) << 14;
      return r;
   endfunction

   // Clamp a CORDIC result to +-1.0 in Q(C).
   function automatic logic [CW-1:0] sat_coef(input logic [LW-1:0] v);
      logic signed [LW-1:0] s;
      s = $signed(v);
      if (s > ONE_L) s = ONE_L;
      else if (s < -ONE_L) s = -ONE_L;
      return s[CW-1:0];
   endfunction

   // Round Q(2C) to Q1.14, ties up, clamp to +-1.0.
   function automatic logic [OUT_W-1:0] entry(input logic [SW-1:0] q);
      logic signed [SW-1:0] t;
      logic signed [SW-1:0] one_w;
      one_w = SW'(OUT_ONE);
      t = $signed(q) + $signed(SW'(1) << (SH - 1));
      t = t >>> SH;
      if (t > one_w) t = one_w;
      else if (t < -one_w) t = -one_w;
      return t[OUT_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== design/eatm_cordic_cell.sv =====
// One CORDIC rotation cell: rotates three angle lanes by one micro-angle.
// Depends on eatm_pkg; a row of these forms the sin/cos pipeline.
`default_nettype none
module eatm_cordic_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       en,
   input  wire [eatm_pkg::IDX_W-1:0] idx,
   input  eatm_pkg::pipe_type        in_data,
   output eatm_pkg::pipe_type        out_data
);
   import eatm_pkg::*;

   pipe_type out_ff, out_in;

   // micro-rotation toward zero residual
   always_comb begin
      logic signed [LW-1:0] xs, ys, x, y;
      logic signed [ZW-1:0] z, at;
      out_in = in_data;
      at = $signed(ATAN_TAB[idx]);
      for (int k = 0; k < 3; k++) begin
         x = $signed(in_data.lane[k].x);
         y = $signed(in_data.lane[k].y);
         z = $signed(in_data.lane[k].z);
         xs = x >>> idx;
         ys = y >>> idx;
         if (!z[ZW-1]) begin
            out_in.lane[k].x = x - ys;
            out_in.lane[k].y = y + xs;
            out_in.lane[k].z = z - at;
         end else begin
            out_in.lane[k].x = x + ys;
            out_in.lane[k].y = y - xs;
            out_in.lane[k].z = z + at;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff <= out_in;
      end
   end

   assign out_data = out_ff;

endmodule
`default_nettype wire

// ===== design/eatm_matrix.sv =====
// Matrix assembly: saturates sin/cos, forms the products, rounds entries.
// Depends on eatm_pkg; four register stages, the last one drives rsp.
`default_nettype none
module eatm_matrix (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       en,
   input  eatm_pkg::pipe_type        in_data,
   output logic                      out_valid,
   output logic [eatm_pkg::RSP_W-1:0] out_data
);
   import eatm_pkg::*;

   // stage 1: sin/cos per angle (0 pitch, 1 yaw, 2 roll)
   logic               v1_ff;
   logic [CW-1:0]      s1_ff [3];
   logic [CW-1:0]      c1_ff [3];
   logic [3*POS_W-1:0] pos1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_data.valid;
      end
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            s1_ff[k] <= sat_coef(in_data.lane[k].y);
            c1_ff[k] <= in_data.neg[k] ? CW'(-$signed(sat_coef(in_data.lane[k].x)))
                                       : sat_coef(in_data.lane[k].x);
         end
         pos1_ff <= in_data.pos;
      end
   end

   // stage 2: first products, pitch-roll terms rounded to Q(C)
   logic               v2_ff;
   logic [PW-1:0]      p00_ff, p01_ff, p12_ff, p22_ff, p02_ff;
   logic [CW-1:0]      pr_ff, pc_ff, sy2_ff, cy2_ff, sr2_ff, cr2_ff;
   logic [3*POS_W-1:0] pos2_ff;
   logic signed [PW-1:0] pr_in, pc_in;

   always_comb begin
      logic signed [PW-1:0] ra, rb;
      ra = $signed(s1_ff[0]) * $signed(s1_ff[2]);
      rb = $signed(s1_ff[0]) * $signed(c1_ff[2]);
      pr_in = (ra + $signed(PW'(1) << (COEF_BITS - 1))) >>> COEF_BITS;
      pc_in = (rb + $signed(PW'(1) << (COEF_BITS - 1))) >>> COEF_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         p00_ff  <= $signed(c1_ff[0]) * $signed(c1_ff[1]);
         p01_ff  <= $signed(c1_ff[0]) * $signed(s1_ff[1]);
         p12_ff  <= $signed(s1_ff[2]) * $signed(c1_ff[0]);
         p22_ff  <= $signed(c1_ff[2]) * $signed(c1_ff[0]);
         p02_ff  <= PW'(-$signed(s1_ff[0])) << COEF_BITS;
         pr_ff   <= pr_in[CW-1:0];
         pc_ff   <= pc_in[CW-1:0];
         sy2_ff  <= s1_ff[1];
         cy2_ff  <= c1_ff[1];
         sr2_ff  <= s1_ff[2];
         cr2_ff  <= c1_ff[2];
         pos2_ff <= pos1_ff;
      end
   end

   // stage 3: second products for the mixed entries
   logic               v3_ff;
   logic [PW-1:0]      a10_ff, b10_ff, a11_ff, b11_ff, a20_ff, b20_ff, a21_ff, b21_ff;
   logic [PW-1:0]      q00_ff, q01_ff, q02_ff, q12_ff, q22_ff;
   logic [3*POS_W-1:0] pos3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         a10_ff  <= $signed(pr_ff) * $signed(cy2_ff);
         b10_ff  <= $signed(cr2_ff) * $signed(sy2_ff);
         a11_ff  <= $signed(pr_ff) * $signed(sy2_ff);
         b11_ff  <= $signed(cr2_ff) * $signed(cy2_ff);
         a20_ff  <= $signed(pc_ff) * $signed(cy2_ff);
         b20_ff  <= $signed(sr2_ff) * $signed(sy2_ff);
         a21_ff  <= $signed(pc_ff) * $signed(sy2_ff);
         b21_ff  <= $signed(sr2_ff) * $signed(cy2_ff);
         q00_ff  <= p00_ff;
         q01_ff  <= p01_ff;
         q02_ff  <= p02_ff;
         q12_ff  <= p12_ff;
         q22_ff  <= p22_ff;
         pos3_ff <= pos2_ff;
      end
   end

   // stage 4: sums, rounding to Q1.14, output register
   logic               v4_ff;
   logic [RSP_W-1:0]   d4_ff, d4_in;

   always_comb begin
      logic signed [SW-1:0] s10, s11, s20, s21;
      s10 = SW'($signed(a10_ff)) - SW'($signed(b10_ff));
      s11 = SW'($signed(a11_ff)) + SW'($signed(b11_ff));
      s20 = SW'($signed(a20_ff)) + SW'($signed(b20_ff));
      s21 = SW'($signed(a21_ff)) - SW'($signed(b21_ff));
      d4_in = '0;
      d4_in[15:0]    = entry(SW'($signed(q00_ff)));
      d4_in[31:16]   = entry(SW'($signed(q01_ff)));
      d4_in[47:32]   = entry(SW'($signed(q02_ff)));
      d4_in[63:48]   = entry(s10);
      d4_in[79:64]   = entry(s11);
      d4_in[95:80]   = entry(SW'($signed(q12_ff)));
      d4_in[111:96]  = entry(s20);
      d4_in[127:112] = entry(s21);
      d4_in[143:128] = entry(SW'($signed(q22_ff)));
      d4_in[200:144] = pos3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         d4_ff <= d4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = d4_ff;

endmodule
`default_nettype wire

// ===== design/euler_angles_to_matrix_core.sv =====
// Euler angles to rotation matrix core (pitch-yaw-roll), fully pipelined.
// Usage:
//   Request channel req_*: one request carries pitch, yaw, roll in 1/64
//   degree and a position in 1/16 unit. Result channel rsp_*: the nine
//   Q1.14 matrix entries and the translation copied from the position.
//   Stages: one wrap/seed stage, one CORDIC cell per stage, four matrix stages
//   (saturate, products, products, round).
//   Throughput: one request per cycle while not stalled; every stage is a
//   register with a common advance enable, the last one the output register.
//   Stall: when rsp_tvalid is high and rsp_tready low the whole pipeline
//   holds and req_tready drops; it is ready again the cycle the result is
//   taken. Bubbles are not squeezed out, so a waiting result holds the
//   input even when empty stages sit behind it.
//   Reset (synchronous, active high) clears all valid bits; no request is
//   in flight afterwards. There is no configuration and no clearing pass.
`default_nettype none
module euler_angles_to_matrix_core (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   // pitch_angle[15:0], yaw_angle[31:16], roll_angle[47:32],
   // pos_x[66:48], pos_y[85:67], pos_z[104:86], zero fill to 112
   input  wire [eatm_pkg::IN_W-1:0]   req_tdata,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   // m00[15:0] m01 m02 m10 m11 m12 m20 m21 m22[143:128],
   // tx[162:144], ty[181:163], tz[200:182], zero fill to 208
   output logic [eatm_pkg::RSP_W-1:0] rsp_tdata
);
   import eatm_pkg::*;
   `include "euler_angles_to_matrix_core_macros.svh"

   logic     en;
   pipe_type stage0_ff, stage0_in;
   pipe_type cord [0:CORDIC_STAGES];

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // wrap, fold and seed all three angles
   always_comb begin
      start_type st;
      stage0_in.valid = req_tvalid;
      for (int k = 0; k < 3; k++) begin
         st = wrap_angle(req_tdata[k*ANG_W +: ANG_W]);
         stage0_in.lane[k] = st.lane;
         stage0_in.neg[k]  = st.neg;
      end
      stage0_in.pos = req_tdata[3*ANG_W +: 3*POS_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage0_ff.valid <= 1'b0;
      end else if (en) begin
         stage0_ff <= stage0_in;
      end
   end

   assign cord[0] = stage0_ff;

   // row of CORDIC cells
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      eatm_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .idx      (IDX_W'(g)),
         .in_data  (cord[g]),
         .out_data (cord[g+1])
      );
   end

   eatm_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_data   (cord[CORDIC_STAGES]),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata)
   );

   `EATM_ASSERT_NEXT(a_req_enters, clock, reset, req_tvalid && req_tready, stage0_ff.valid)
   `EATM_ASSERT_NOW(a_m02_range, clock, reset, rsp_tvalid,
      $signed(rsp_tdata[47:32]) <= 16'sd16384 && $signed(rsp_tdata[47:32]) >= -16'sd16384)
   `EATM_ASSERT_NOW(a_m22_range, clock, reset, rsp_tvalid,
      $signed(rsp_tdata[143:128]) <= 16'sd16384 && $signed(rsp_tdata[143:128]) >= -16'sd16384)

endmodule
`default_nettype wire
